// ----- hdl/skf_pkg.sv -----
// Shared constants and types for the scalar Kalman filter.
package skf_pkg;

  // Gain is unsigned Q1.16 and may reach exactly 1.0
  localparam int unsigned GAIN_BITS = 16;
  localparam int unsigned GAIN_W    = GAIN_BITS + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  // One quotient bit per divide step, one gain bit per multiply step
  localparam int unsigned STEPS  = GAIN_W;
  localparam int unsigned STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  // Configuration register indexes
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_PROCESS_NOISE     = 1'b0;
  localparam cfg_index_t REG_MEASUREMENT_NOISE = 1'b1;

endpackage

// ----- hdl/scalar_kalman_filter.sv -----
// Scalar Kalman filter: bit-serial divider and multiplier around one predict/correct step.
//
// Each accepted sample runs through predict, divide, multiply and finish before the next one is
// accepted: predict the covariance, then a restoring divider that yields one gain bit per
// cycle, then a shift-add multiplier that forms gain times innovation and the covariance
// shrink together (one gain bit per cycle), and last round, clamp and load the result
// register. A zero divisor (covariance plus measurement noise both zero) skips both loops
// and goes straight to the finish. The result stays in its output register until taken; a
// new sample is accepted while it waits, and the following result holds in the finish
// state, stretching the item by the stall, until the output register is free. The user
// must write the noise registers through the cfg port only while no sample is in flight;
// the block itself does not enforce this. FRAC_BITS sets the reset values of the noise
// registers (0.1) and of the covariance (1.0); the gain is always Q1.16.
module scalar_kalman_filter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // sample channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [31:0]       sample,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       estimate,
  output logic [skf_pkg::GAIN_W-1:0] gain,
  output logic                     zero_divisor,
  // configuration write port
  input  logic                     cfg_we,
  input  skf_pkg::cfg_index_t      cfg_index,
  input  logic [31:0]              cfg_data
);

  localparam logic [31:0] COV_RESET   = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] NOISE_RESET = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [35:0] EST_MAX     = 36'h07FFFFFFF;
  localparam logic [35:0] EST_MIN     = 36'hF80000000;

  localparam int unsigned GW = skf_pkg::GAIN_W;

  typedef enum logic [2:0] {
    IDLE,
    PREDICT,
    DIVIDE,
    MULTIPLY,
    FINISH
  } state_t;

  state_t                   state;
  logic [31:0]              process_noise;
  logic [31:0]              measurement_noise;
  logic [31:0]              covariance;
  logic [31:0]              estimate_reg;
  logic [31:0]              sample_reg;
  logic [31:0]              pred;
  logic [32:0]              divisor;
  logic [32:0]              diff;
  logic                     zero;
  logic [33:0]              rem;
  logic [GW-1:0]            quot;
  logic [GW-1:0]            k_sh;
  logic [GW-1:0]            g_sh;
  logic [33:0]              est_hi;
  logic [GW-1:0]            est_lo;
  logic [32:0]              cov_hi;
  logic [GW-1:0]            cov_lo;
  logic [skf_pkg::STEP_W-1:0] cnt;

  logic [32:0]   pn_sum;
  logic [31:0]   pred_next;
  logic [32:0]   divisor_next;
  logic [32:0]   diff_next;
  logic [33:0]   cand;
  logic          ge;
  logic [33:0]   rem_next;
  logic [GW-1:0] k_fin;
  logic [33:0]   s_est;
  logic [32:0]   s_cov;
  logic [34:0]   est_adj;
  logic [35:0]   x_sum;
  logic [31:0]   estimate_next;
  logic [33:0]   cov_rnd;
  logic [31:0]   covariance_next;
  logic          out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  // Predict: saturating covariance growth, divisor and innovation
  always_comb begin
    pn_sum       = {1'b0, covariance} + {1'b0, process_noise};
    pred_next    = pn_sum[32] ? 32'hFFFF_FFFF : pn_sum[31:0];
    divisor_next = {1'b0, pred_next} + {1'b0, measurement_noise};
    diff_next    = {sample_reg[31], sample_reg} - {estimate_reg[31], estimate_reg};
  end

  // Divide step: the first compare has no shift, the rest double the remainder
  always_comb begin
    cand     = (cnt == '0) ? rem : {rem[32:0], 1'b0};
    ge       = (cand >= {1'b0, divisor});
    rem_next = ge ? (cand - {1'b0, divisor}) : cand;
    k_fin    = {quot[GW-2:0], ge};
  end

  // Multiply step: add the partial product, then shift one bit into the low word
  always_comb begin
    s_est = est_hi + (k_sh[0] ? {diff[32], diff} : 34'd0);
    s_cov = cov_hi + (g_sh[0] ? {1'b0, pred} : 33'd0);
  end

  // Finish: round half up, add to the old estimate, clamp; round the covariance
  always_comb begin
    est_adj = {est_hi, est_lo[GW-1]} + {34'd0, est_lo[GW-2]};
    x_sum   = {{4{estimate_reg[31]}}, estimate_reg} + {est_adj[34], est_adj};
    if ($signed(x_sum) > $signed(EST_MAX)) begin
      estimate_next = EST_MAX[31:0];
    end else if ($signed(x_sum) < $signed(EST_MIN)) begin
      estimate_next = EST_MIN[31:0];
    end else begin
      estimate_next = x_sum[31:0];
    end
    cov_rnd         = {cov_hi, cov_lo[GW-1]} + {33'd0, cov_lo[GW-2]};
    covariance_next = (cov_rnd[33:32] != 2'b00) ? 32'hFFFF_FFFF : cov_rnd[31:0];
  end

  // Sequencer, filter state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= IDLE;
      out_valid         <= 1'b0;
      cnt               <= '0;
      process_noise     <= NOISE_RESET;
      measurement_noise <= NOISE_RESET;
      covariance        <= COV_RESET;
      estimate_reg      <= '0;
    end else begin
      // drop the result once it is taken; the finish cycle loads the next one itself
      if (out_valid && out_ready && (state != FINISH)) begin
        out_valid <= 1'b0;
      end

      // noise registers
      if (cfg_we) begin
        case (cfg_index)
          skf_pkg::REG_PROCESS_NOISE:     process_noise     <= cfg_data;
          skf_pkg::REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        IDLE: begin
          if (in_valid) begin
            sample_reg <= sample;
            state      <= PREDICT;
          end
        end
        PREDICT: begin
          pred    <= pred_next;
          divisor <= divisor_next;
          diff    <= diff_next;
          zero    <= (divisor_next == '0);
          rem     <= {2'b00, pred_next};
          quot    <= '0;
          cnt     <= '0;
          state   <= (divisor_next == '0) ? FINISH : DIVIDE;
        end
        DIVIDE: begin
          rem  <= rem_next;
          quot <= k_fin;
          if (cnt == skf_pkg::LAST_STEP) begin
            k_sh   <= k_fin;
            g_sh   <= skf_pkg::GAIN_ONE - k_fin;
            est_hi <= '0;
            est_lo <= '0;
            cov_hi <= '0;
            cov_lo <= '0;
            cnt    <= '0;
            state  <= MULTIPLY;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        MULTIPLY: begin
          est_hi <= {s_est[33], s_est[33:1]};
          est_lo <= {s_est[0], est_lo[GW-1:1]};
          cov_hi <= {1'b0, s_cov[32:1]};
          cov_lo <= {s_cov[0], cov_lo[GW-1:1]};
          k_sh   <= k_sh >> 1;
          g_sh   <= g_sh >> 1;
          if (cnt == skf_pkg::LAST_STEP) begin
            cnt   <= '0;
            state <= FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        FINISH: begin
          // hold here while the previous result still waits
          if (out_free) begin
            out_valid    <= 1'b1;
            zero_divisor <= zero;
            if (zero) begin
              covariance <= pred;
              estimate   <= estimate_reg;
              gain       <= '0;
            end else begin
              covariance   <= covariance_next;
              estimate_reg <= estimate_next;
              estimate     <= estimate_next;
              gain         <= quot;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/skf_checker.sv -----
// Port-level checker for the scalar Kalman filter, bound to the top level.
module skf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [31:0]         estimate,
  input logic [skf_pkg::GAIN_W-1:0] gain,
  input logic                       zero_divisor
);

  // gain never exceeds 1.0
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gain <= skf_pkg::GAIN_ONE))
    else $error("gain above 1.0");

  // a zero divisor always reports a zero gain
  a_zero_gain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_divisor) |-> (gain == '0))
    else $error("zero divisor with nonzero gain");

  // the block is busy right after it takes a sample beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sample accepted while still busy");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(estimate) && $stable(gain)
                                   && $stable(zero_divisor)))
    else $error("result beat changed while stalled");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .estimate     (estimate),
  .gain         (gain),
  .zero_divisor (zero_divisor)
);
